/* hdl/fibonacci_matrix_power_assert.svh */
// ----------------------------------------------------------------------------
// fibonacci_matrix_power_assert.svh
// assertion macros shared by the fibonacci matrix power rtl
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_MATRIX_POWER_ASSERT_SVH
`define FIBONACCI_MATRIX_POWER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, off during reset
`define FMP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fmp assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define FMP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fmp assertion failed");

`else

`define FMP_ASSERT_IMPL(label, ante, cons)
`define FMP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/fmp_pkg.sv */
// ----------------------------------------------------------------------------
// fmp_pkg
// types and constants shared by the fibonacci matrix power block
// ----------------------------------------------------------------------------
package fmp_pkg;

   localparam int INDEX_BITS_DEFAULT = 7;
   localparam int FIB_WIDTH          = 64;
   localparam int HALF_WIDTH         = FIB_WIDTH / 2;

   // largest index whose fibonacci number fits in 64 bits
   localparam logic [31:0] LAST_EXACT_INDEX = 32'd93;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DRAIN,
      ST_COMBINE,
      ST_STEPQ,
      ST_DONE
   } fmp_state_type;

   // partial products of one doubling step on (a, b) = (F(k), F(k+1))
   typedef enum logic [2:0] {
      MOP_AA_LL,
      MOP_AA_HL,
      MOP_BB_LL,
      MOP_BB_HL,
      MOP_AB_LL,
      MOP_AB_HL,
      MOP_AB_LH
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       shift;
      logic       mul_en;
      mul_op_type mul_op;
      logic       combine;
      logic       step_q;
      logic       emit;
   } fmp_cmd_type;

   typedef struct packed {
      logic e_msb;
   } fmp_status_type;

endpackage

/* hdl/fmp_if.sv */
// ----------------------------------------------------------------------------
// fmp_if
// valid/ready channels for the index requests and the fibonacci responses
// ----------------------------------------------------------------------------
interface fmp_req_if #(
   parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] index;

   modport source (output valid, output index, input ready);
   modport sink   (input valid, input index, output ready);
endinterface

interface fmp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fmp_pkg::FIB_WIDTH-1:0]  fib_value;
   logic                           overflow;

   modport source (output valid, output fib_value, output overflow, input ready);
   modport sink   (input valid, input fib_value, input overflow, output ready);
endinterface

/* hdl/fmp_datapath.sv */
// ----------------------------------------------------------------------------
// fmp_datapath
// fibonacci pair registers, shared 32x32 multiplier and result register
// ----------------------------------------------------------------------------
module fmp_datapath #(
   parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [INDEX_BITS-1:0]          index,
   input  fmp_pkg::fmp_cmd_type           cmd,
   output fmp_pkg::fmp_status_type        status,
   output logic [fmp_pkg::FIB_WIDTH-1:0]  fib_value,
   output logic                           overflow
);
   import fmp_pkg::*;

   // pair (a, b) = (F(k), F(k+1)) and the three square/cross products
   logic [FIB_WIDTH-1:0]  a_ff, a_in, b_ff, b_in;
   logic [FIB_WIDTH-1:0]  sqa_ff, sqa_in, sqb_ff, sqb_in, ab_ff, ab_in;
   logic [FIB_WIDTH-1:0]  prod_ff, prod_in;
   mul_op_type            pop_ff;
   logic                  pvalid_ff;
   logic [INDEX_BITS-1:0] e_ff, e_in;
   logic                  zero_ff, ovf_ff;
   logic [FIB_WIDTH-1:0]  fib_ff;
   logic                  ovf_out_ff;
   logic [HALF_WIDTH-1:0] mul_x, mul_y;
   logic [FIB_WIDTH-1:0]  dbl_a, dbl_b;

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.mul_op)
         MOP_AA_LL: begin
            mul_x = a_ff[HALF_WIDTH-1:0];
            mul_y = a_ff[HALF_WIDTH-1:0];
         end
         MOP_AA_HL: begin
            mul_x = a_ff[FIB_WIDTH-1:HALF_WIDTH];
            mul_y = a_ff[HALF_WIDTH-1:0];
         end
         MOP_BB_LL: begin
            mul_x = b_ff[HALF_WIDTH-1:0];
            mul_y = b_ff[HALF_WIDTH-1:0];
         end
         MOP_BB_HL: begin
            mul_x = b_ff[FIB_WIDTH-1:HALF_WIDTH];
            mul_y = b_ff[HALF_WIDTH-1:0];
         end
         MOP_AB_LL: begin
            mul_x = a_ff[HALF_WIDTH-1:0];
            mul_y = b_ff[HALF_WIDTH-1:0];
         end
         MOP_AB_HL: begin
            mul_x = a_ff[FIB_WIDTH-1:HALF_WIDTH];
            mul_y = b_ff[HALF_WIDTH-1:0];
         end
         MOP_AB_LH: begin
            mul_x = a_ff[HALF_WIDTH-1:0];
            mul_y = b_ff[FIB_WIDTH-1:HALF_WIDTH];
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;

   // fold the registered partial product into its accumulator
   always_comb begin
      sqa_in = sqa_ff;
      sqb_in = sqb_ff;
      ab_in  = ab_ff;
      if (pvalid_ff) begin
         unique case (pop_ff)
            MOP_AA_LL: sqa_in = prod_ff;
            MOP_AA_HL: sqa_in = sqa_ff + {prod_ff[HALF_WIDTH-2:0], {(HALF_WIDTH+1){1'b0}}};
            MOP_BB_LL: sqb_in = prod_ff;
            MOP_BB_HL: sqb_in = sqb_ff + {prod_ff[HALF_WIDTH-2:0], {(HALF_WIDTH+1){1'b0}}};
            MOP_AB_LL: ab_in  = prod_ff;
            MOP_AB_HL: ab_in  = ab_ff + {prod_ff[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};
            MOP_AB_LH: ab_in  = ab_ff + {prod_ff[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};
            default:   ab_in  = ab_ff;
         endcase
      end
   end

   // doubling: F(2k) = 2 F(k) F(k+1) - F(k)^2, F(2k+1) = F(k)^2 + F(k+1)^2
   assign dbl_a = {ab_ff[FIB_WIDTH-2:0], 1'b0} - sqa_ff;
   assign dbl_b = sqa_ff + sqb_ff;

   // pair update and exponent shift
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      e_in = e_ff;
      if (cmd.load) begin
         a_in = '0;
         b_in = FIB_WIDTH'(1);
         e_in = (index == '0) ? '0 : index - {{(INDEX_BITS-1){1'b0}}, 1'b1};
      end else begin
         if (cmd.combine) begin
            a_in = dbl_a;
            b_in = dbl_b;
         end else if (cmd.step_q) begin
            a_in = b_ff;
            b_in = a_ff + b_ff;
         end
         if (cmd.shift) begin
            e_in = {e_ff[INDEX_BITS-2:0], 1'b0};
         end
      end
   end

   // control register of the multiplier pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.mul_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      e_ff    <= e_in;
      sqa_ff  <= sqa_in;
      sqb_ff  <= sqb_in;
      ab_ff   <= ab_in;
      prod_ff <= prod_in;
      pop_ff  <= cmd.mul_op;
      if (cmd.load) begin
         zero_ff <= (index == '0);
         ovf_ff  <= (32'(index) > LAST_EXACT_INDEX);
      end
      if (cmd.emit) begin
         fib_ff     <= zero_ff ? '0 : b_ff;
         ovf_out_ff <= ovf_ff;
      end
   end

   assign status.e_msb = e_ff[INDEX_BITS-1];
   assign fib_value    = fib_ff;
   assign overflow     = ovf_out_ff;

endmodule

/* hdl/fmp_controller.sv */
// ----------------------------------------------------------------------------
// fmp_controller
// sequencer over the exponent bits and the multiplier partial products
// ----------------------------------------------------------------------------
`include "fibonacci_matrix_power_assert.svh"

module fmp_controller #(
   parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  fmp_pkg::fmp_status_type  status,
   output fmp_pkg::fmp_cmd_type     cmd
);
   import fmp_pkg::*;

   localparam int CntBits = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
   localparam logic [CntBits-1:0] CntLast = CntBits'(INDEX_BITS - 1);

   fmp_state_type      state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               started_ff, started_in;
   mul_op_type         op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         op_ff        <= MOP_AA_LL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      started_in  = started_ff;
      op_in       = op_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.mul_op  = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               cnt_in     = CntLast;
               started_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // leading zero bits leave the identity pair untouched
            if (!started_ff && !status.e_msb) begin
               cmd.shift = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in   = cnt_ff - CntBits'(1);
                  state_in = ST_SCAN;
               end
            end else begin
               started_in = 1'b1;
               op_in      = MOP_AA_LL;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (op_ff == MOP_AB_LH) begin
               state_in = ST_DRAIN;
            end else begin
               op_in = mul_op_type'(3'(op_ff + 3'd1));
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            if (status.e_msb) begin
               state_in = ST_STEPQ;
            end else begin
               cmd.shift = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in   = cnt_ff - CntBits'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_STEPQ: begin
            cmd.step_q = 1'b1;
            cmd.shift  = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff - CntBits'(1);
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response beat valid
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FMP_ASSERT_IMPL(a_combine_after_drain, state_ff == ST_COMBINE, $past(state_ff) == ST_DRAIN)
   `FMP_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp_valid_ff)
   `FMP_ASSERT_NEXT(a_done_holds_on_stall, state_ff == ST_DONE && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)
   `FMP_ASSERT_IMPL(a_mul_only_after_start, state_ff == ST_MUL, started_ff)

endmodule

/* hdl/fibonacci_matrix_power.sv */
// ----------------------------------------------------------------------------
// fibonacci_matrix_power
// fibonacci number of an index by doubling of the fibonacci matrix power
// ----------------------------------------------------------------------------
// usage:
//   req carries one index per beat, rsp one fib_value and overflow per beat;
//   both are valid/ready, a beat moves when valid and ready are high together.
//   overflow is set for indices above 93, fib_value then wraps modulo 2^64.
// sequencing:
//   one index is in the sequencer at a time. a leading zero bit of index-1
//   only shifts the exponent; each bit from the leading one down runs the
//   single 32x32 multiplier through seven partial products for F(k)^2,
//   F(k+1)^2 and F(k)F(k+1), then a drain and a combine step, and a set bit
//   adds a step to (F(k+1), F(k)+F(k+1)). the sequencer is back in idle,
//   ready for the next request, when rsp valid rises.
// reset:
//   synchronous; returns the sequencer to idle and drops rsp valid.
// stall:
//   the result register holds while rsp is stalled; a new request is taken
//   meanwhile, and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power #(
   parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   fmp_req_if.sink   req,
   fmp_rsp_if.source rsp
);
   import fmp_pkg::*;

   fmp_cmd_type    cmd;
   fmp_status_type status;

   fmp_controller #(
      .INDEX_BITS (INDEX_BITS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fmp_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .index     (req.index),
      .cmd       (cmd),
      .status    (status),
      .fib_value (rsp.fib_value),
      .overflow  (rsp.overflow)
   );

endmodule
